/* hw/rtl/clr_pkg.sv */
package clr_pkg;

	localparam int COORD_W = 17;
	localparam int DIFF_W  = 18;
	localparam int MAG_W   = 17;
	localparam int PROD_W  = 2 * MAG_W;
	localparam int PIX_W   = 6;
	localparam int SIDE_W  = 7;
	localparam int COLOR_W = 16;
	localparam int IN_W    = 16;
	localparam int ERR_W   = 8;

	localparam logic [3:0] EDGE_LEFT   = 4'b0001;
	localparam logic [3:0] EDGE_RIGHT  = 4'b0010;
	localparam logic [3:0] EDGE_TOP    = 4'b0100;
	localparam logic [3:0] EDGE_BOTTOM = 4'b1000;

	localparam logic [3:0] MAX_CROSSINGS = 4'd8;
	localparam logic [PIX_W-1:0] LAST_COUNT = 6'd63;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [PIX_W-1:0]   x0;
		logic [PIX_W-1:0]   y0;
		logic [PIX_W-1:0]   x1;
		logic [PIX_W-1:0]   y1;
		logic [COLOR_W-1:0] color;
	} seg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

/* hw/rtl/clr_ifs.sv */
interface clr_cmd_if;
	logic              valid;
	logic              ready;
	logic signed [15:0] start_x;
	logic signed [15:0] start_y;
	logic signed [15:0] end_x;
	logic signed [15:0] end_y;
	logic [15:0]        line_color;

	modport source (output valid, start_x, start_y, end_x, end_y, line_color, input ready);
	modport sink (input valid, start_x, start_y, end_x, end_y, line_color, output ready);
endinterface

interface clr_pix_if;
	logic        valid;
	logic        ready;
	logic [5:0]  pixel_x;
	logic [5:0]  pixel_y;
	logic [15:0] pixel_color;
	logic        final_pixel;

	modport source (output valid, pixel_x, pixel_y, pixel_color, final_pixel, input ready);
	modport sink (input valid, pixel_x, pixel_y, pixel_color, final_pixel, output ready);
endinterface

/* hw/rtl/clr_clipper.sv */
module clr_clipper
	import clr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	clr_cmd_if.sink           cmd,
	input  logic [SIDE_W-1:0] canvas_w,
	input  logic [SIDE_W-1:0] canvas_h,
	input  q_stat_t           q_stat,
	output logic              push,
	output seg_t              push_seg
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_EVAL = 6'b000010,
		S_MUL  = 6'b000100,
		S_DIV  = 6'b001000,
		S_UPD  = 6'b010000,
		S_PUSH = 6'b100000
	} state_t;

	function automatic logic [3:0] region(input coord_t x, input coord_t y,
		input logic [PIX_W-1:0] mx, input logic [PIX_W-1:0] my);
		logic [3:0] c;
		c = 4'b0000;
		if (x < 0) c = c | EDGE_LEFT;
		else if (x > $signed({{(COORD_W-PIX_W){1'b0}}, mx})) c = c | EDGE_RIGHT;
		if (y < 0) c = c | EDGE_TOP;
		else if (y > $signed({{(COORD_W-PIX_W){1'b0}}, my})) c = c | EDGE_BOTTOM;
		return c;
	endfunction

	function automatic logic [MAG_W-1:0] magn(input logic signed [DIFF_W-1:0] v);
		logic signed [DIFF_W-1:0] a;
		a = v[DIFF_W-1] ? -v : v;
		return a[MAG_W-1:0];
	endfunction

	state_t             state_q;
	coord_t             x0_q, y0_q, x1_q, y1_q;
	logic [COLOR_W-1:0] color_q;
	logic [PIX_W-1:0]   mx_q, my_q;
	logic               zero_q;
	logic [3:0]         n_q;
	logic               side1_q;
	logic               calc_x_q;
	coord_t             base_q;
	coord_t             other_q;
	logic               neg_q;
	logic [PROD_W-1:0]  mcand_q;
	logic [MAG_W-1:0]   mb_q;
	logic [MAG_W-1:0]   md_q;
	logic [PROD_W-1:0]  prod_q;
	logic [MAG_W:0]     rem_q;
	logic [5:0]         cnt_q;

	logic [3:0]               c0, c1, c;
	logic signed [DIFF_W-1:0] dxs, dys, a_s, b_s, d_s;
	coord_t                   base_c, other_c;
	logic                     calc_x_c;
	logic [MAG_W:0]           rem_sh;
	logic [MAG_W:0]           rem_sub;
	logic signed [DIFF_W-1:0] q_s, val_s;
	coord_t                   val_c;

	always_comb begin
		c0 = region(x0_q, y0_q, mx_q, my_q);
		c1 = region(x1_q, y1_q, mx_q, my_q);
		c = (c0 != 4'b0000) ? c0 : c1;
		dxs = DIFF_W'(x1_q) - DIFF_W'(x0_q);
		dys = DIFF_W'(y1_q) - DIFF_W'(y0_q);
		priority if ((c & EDGE_TOP) != 4'b0000) begin
			a_s = dxs;
			b_s = -DIFF_W'(y0_q);
			d_s = dys;
			base_c = x0_q;
			other_c = '0;
			calc_x_c = 1'b1;
		end else if ((c & EDGE_BOTTOM) != 4'b0000) begin
			a_s = dxs;
			b_s = $signed({{(DIFF_W-PIX_W){1'b0}}, my_q}) - DIFF_W'(y0_q);
			d_s = dys;
			base_c = x0_q;
			other_c = $signed({{(COORD_W-PIX_W){1'b0}}, my_q});
			calc_x_c = 1'b1;
		end else if ((c & EDGE_RIGHT) != 4'b0000) begin
			a_s = dys;
			b_s = $signed({{(DIFF_W-PIX_W){1'b0}}, mx_q}) - DIFF_W'(x0_q);
			d_s = dxs;
			base_c = y0_q;
			other_c = $signed({{(COORD_W-PIX_W){1'b0}}, mx_q});
			calc_x_c = 1'b0;
		end else begin
			a_s = dys;
			b_s = -DIFF_W'(x0_q);
			d_s = dxs;
			base_c = y0_q;
			other_c = '0;
			calc_x_c = 1'b0;
		end
		rem_sh = {rem_q[MAG_W-1:0], prod_q[PROD_W-1]};
		rem_sub = rem_sh - {1'b0, md_q};
		q_s = $signed({1'b0, prod_q[MAG_W-1:0]});
		val_s = DIFF_W'(base_q) + (neg_q ? -q_s : q_s);
		val_c = val_s[COORD_W-1:0];
	end

	assign cmd.ready = (state_q == S_IDLE);
	assign push = (state_q == S_PUSH) && !q_stat.full;
	assign push_seg = '{x0: x0_q[PIX_W-1:0], y0: y0_q[PIX_W-1:0],
		x1: x1_q[PIX_W-1:0], y1: y1_q[PIX_W-1:0], color: color_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) state_q <= S_EVAL;
				end
				S_EVAL: begin
					priority if (zero_q) state_q <= S_IDLE;
					else if ((c0 | c1) == 4'b0000) state_q <= S_PUSH;
					else if ((c0 & c1) != 4'b0000) state_q <= S_IDLE;
					else if (n_q == MAX_CROSSINGS) state_q <= S_IDLE;
					else if (d_s == '0) state_q <= S_IDLE;
					else state_q <= S_MUL;
				end
				S_MUL: begin
					if (cnt_q == 6'(MAG_W - 1)) state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == 6'(PROD_W - 1)) state_q <= S_UPD;
				end
				S_UPD: state_q <= S_EVAL;
				S_PUSH: begin
					if (!q_stat.full) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				x0_q <= COORD_W'(cmd.start_x);
				y0_q <= COORD_W'(cmd.start_y);
				x1_q <= COORD_W'(cmd.end_x);
				y1_q <= COORD_W'(cmd.end_y);
				color_q <= cmd.line_color;
				zero_q <= (canvas_w == '0) || (canvas_h == '0);
				mx_q <= PIX_W'(canvas_w - SIDE_W'(1));
				my_q <= PIX_W'(canvas_h - SIDE_W'(1));
				n_q <= '0;
			end
			S_EVAL: begin
				side1_q <= (c0 == 4'b0000);
				calc_x_q <= calc_x_c;
				base_q <= base_c;
				other_q <= other_c;
				neg_q <= a_s[DIFF_W-1] ^ b_s[DIFF_W-1] ^ d_s[DIFF_W-1];
				mcand_q <= PROD_W'(magn(a_s));
				mb_q <= magn(b_s);
				md_q <= magn(d_s);
				prod_q <= '0;
				cnt_q <= '0;
			end
			S_MUL: begin
				if (mb_q[0]) prod_q <= prod_q + mcand_q;
				mcand_q <= mcand_q << 1;
				mb_q <= mb_q >> 1;
				rem_q <= '0;
				cnt_q <= (cnt_q == 6'(MAG_W - 1)) ? '0 : cnt_q + 6'd1;
			end
			S_DIV: begin
				if (!rem_sub[MAG_W]) begin
					rem_q <= rem_sub;
					prod_q <= {prod_q[PROD_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					prod_q <= {prod_q[PROD_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 6'd1;
			end
			S_UPD: begin
				n_q <= n_q + 4'd1;
				if (side1_q) begin
					x1_q <= calc_x_q ? val_c : other_q;
					y1_q <= calc_x_q ? other_q : val_c;
				end else begin
					x0_q <= calc_x_q ? val_c : other_q;
					y0_q <= calc_x_q ? other_q : val_c;
				end
			end
			S_PUSH: begin
			end
			default: begin
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL || state_q == S_DIV) |-> md_q != '0)
		else $error("Crossing divisor is zero during arithmetic.");

	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ((c0 | c1) == 4'b0000))
		else $error("Pushed segment is not inside the canvas.");

endmodule

/* hw/rtl/clr_queue.sv */
module clr_queue
	import clr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  seg_t    push_seg,
	input  logic    pop,
	output seg_t    head,
	output q_stat_t q_stat
);

	seg_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign head = mem_q[rd_q];
	assign q_stat.full = (cnt_q == 2'd2);
	assign q_stat.empty = (cnt_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_seg;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_stat.full) && !(pop && q_stat.empty))
		else $error("Queue overflow or underflow.");

endmodule

/* hw/rtl/clr_stepper.sv */
module clr_stepper
	import clr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  seg_t    head,
	input  q_stat_t q_stat,
	output logic    pop,
	clr_pix_if.source pixel
);

	logic                    active_q;
	logic [PIX_W-1:0]        cx_q, cy_q, ex_q, ey_q;
	logic                    sx_neg_q, sy_neg_q;
	logic signed [ERR_W-1:0] dx_q, dy_q, err_q;
	logic [PIX_W-1:0]        count_q;
	logic [COLOR_W-1:0]      color_q;
	logic                    out_valid_q;
	logic [PIX_W-1:0]        out_x_q, out_y_q;
	logic [COLOR_W-1:0]      out_color_q;
	logic                    out_final_q;

	logic                    advance;
	logic                    last;
	logic signed [ERR_W:0]   e2, err_n;
	logic                    step_x, step_y;
	logic signed [ERR_W-1:0] hdx, hdy;

	always_comb begin
		advance = active_q && (!out_valid_q || pixel.ready);
		last = ((cx_q == ex_q) && (cy_q == ey_q)) || (count_q == LAST_COUNT);
		e2 = {err_q, 1'b0};
		step_x = (e2 >= (ERR_W+1)'(dy_q));
		step_y = (e2 <= (ERR_W+1)'(dx_q));
		err_n = (ERR_W+1)'(err_q) + (step_x ? (ERR_W+1)'(dy_q) : '0)
			+ (step_y ? (ERR_W+1)'(dx_q) : '0);
		hdx = (head.x1 >= head.x0) ? ERR_W'(head.x1 - head.x0) : ERR_W'(head.x0 - head.x1);
		hdy = (head.y1 >= head.y0) ? ERR_W'(head.y1 - head.y0) : ERR_W'(head.y0 - head.y1);
	end

	assign pop = !active_q && !q_stat.empty;

	assign pixel.valid = out_valid_q;
	assign pixel.pixel_x = out_x_q;
	assign pixel.pixel_y = out_y_q;
	assign pixel.pixel_color = out_color_q;
	assign pixel.final_pixel = out_final_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) active_q <= 1'b1;
			else if (advance && last) active_q <= 1'b0;
			if (advance) out_valid_q <= 1'b1;
			else if (pixel.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cx_q <= head.x0;
			cy_q <= head.y0;
			ex_q <= head.x1;
			ey_q <= head.y1;
			sx_neg_q <= !(head.x0 < head.x1);
			sy_neg_q <= !(head.y0 < head.y1);
			dx_q <= hdx;
			dy_q <= -hdy;
			err_q <= hdx - hdy;
			count_q <= '0;
			color_q <= head.color;
		end else if (advance) begin
			out_x_q <= cx_q;
			out_y_q <= cy_q;
			out_color_q <= color_q;
			out_final_q <= last;
			count_q <= count_q + PIX_W'(1);
			err_q <= err_n[ERR_W-1:0];
			if (step_x) cx_q <= sx_neg_q ? cx_q - PIX_W'(1) : cx_q + PIX_W'(1);
			if (step_y) cy_q <= sy_neg_q ? cy_q - PIX_W'(1) : cy_q + PIX_W'(1);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pixel.ready) |=> (out_valid_q && $stable(out_x_q)
			&& $stable(out_y_q) && $stable(out_final_q)))
		else $error("Pixel beat changed while stalled.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last) |=> !active_q)
		else $error("Stepper did not stop on the last pixel.");

endmodule

/* hw/rtl/clipped_line_rasterizer_unit.sv */
// Port      Dir  Role
// cmd       in   line command beat: two endpoints and a color
// pixel     out  pixel beat: column, row, color, last-pixel mark
// psel..    in   APB register port: canvas_width at 0, canvas_height at 4
//
// The clipper takes one command at a time: each crossing takes 17 multiply
// steps, 34 divide steps, one update and one evaluation, at most eight
// crossings. The stepper emits one pixel per cycle while the pixel port is
// ready, after loading each segment, fed through a two-entry segment queue.
// Reset is asynchronous and needs no clearing pass. A stalled pixel port only
// stops the stepper; the clipper keeps working until the queue is full.
module clipped_line_rasterizer_unit
	import clr_pkg::*;
#(
	parameter int MAX_SIDE = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	clr_cmd_if.sink     cmd,
	clr_pix_if.source   pixel,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [SIDE_W-1:0] width_q, height_q;
	logic [SIDE_W-1:0] canvas_w, canvas_h;
	logic              push, pop;
	seg_t              push_seg, head;
	q_stat_t           q_stat;
	reg_idx_t          idx;

	assign idx = reg_idx_t'(paddr[2]);
	assign pready = 1'b1;
	assign canvas_w = (width_q > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : width_q;
	assign canvas_h = (height_q > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : height_q;

	always_comb begin
		unique case (idx)
			REG_WIDTH:  prdata = {{(32-SIDE_W){1'b0}}, width_q};
			REG_HEIGHT: prdata = {{(32-SIDE_W){1'b0}}, height_q};
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= SIDE_W'(64);
			height_q <= SIDE_W'(64);
		end else if (psel && penable && pwrite && pready) begin
			unique case (idx)
				REG_WIDTH:  width_q <= pwdata[SIDE_W-1:0];
				REG_HEIGHT: height_q <= pwdata[SIDE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	clr_clipper u_clipper (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.canvas_w (canvas_w),
		.canvas_h (canvas_h),
		.q_stat   (q_stat),
		.push     (push),
		.push_seg (push_seg)
	);

	clr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_seg (push_seg),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	clr_stepper u_stepper (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.pixel  (pixel)
	);

endmodule
